### design/fpra_pkg.sv
// Package for the framed packet receiver: payload structs for the input and
// result channels, protocol constants and the front-to-back command format.
// No dependencies.
`default_nettype none

package fpra_pkg;

  localparam logic [7:0] TagAck  = 8'hAA;
  localparam logic [7:0] TagData = 8'hDD;
  localparam logic [7:0] TagEnd  = 8'hEE;
  localparam logic [7:0] SeqNone = 8'hFF;

  localparam logic [15:0] TimeoutReset = 16'd10;

  // Request codes for req_type.
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  // Result kinds.
  localparam logic [1:0] KindAckSend = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindAckRecv = 2'd2;
  localparam logic [1:0] KindReject  = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_value;
    logic       out_last;
  } out_t;

  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_ACK_RX,
    CMD_DATA
  } cmd_kind_e;

  // One finished frame, as handed from the parser to the result sequencer.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] seq;
    logic       stream;   // payload bytes are to be delivered
    logic [7:0] count;    // number of payload bytes
  } cmd_t;

endpackage

`default_nettype wire

### design/framed_packet_receiver_with_ack.sv
// Top level of the framed packet receiver: parser front end, command queue
// and result sequencer. Depends on fpra_pkg, fpra_front, fpra_cmd_fifo, fpra_back.
//
//   Channel   Direction  Handshake           Payload
//   input     in         push_i / full_o     in_i  (req_type, rx_byte)
//   result    out        empty_o / pop_i     out_o (out_kind, out_value, out_last)
//   config    in         cfg_we_i            cfg_wdata_i (rx_timeout_ticks)
//
// The parser takes one byte or tick per cycle. Each finished frame yields one
// command; the sequencer emits the ack or status result and then each payload
// byte by a read state and a load state, set by the registered read of the store.
// Payload bytes of a following frame wait while the store is still streaming,
// and the parser also stalls when the two-entry command queue is full.
// Reset is asynchronous and active low; the frame store is not cleared.
`default_nettype none

module framed_packet_receiver_with_ack
  import fpra_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_t         in_i,
  input  wire logic        push_i,
  output logic             full_o,
  output out_t             out_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic          fifo_full, fifo_empty, fifo_rd, cmd_push, back_active;
  cmd_t          cmd_in, cmd_out;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  fpra_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fifo_full_i (fifo_full),
    .mem_busy_i  (back_active || !fifo_empty),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  fpra_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (fifo_full),
    .rd_i    (fifo_rd),
    .rdata_o (cmd_out),
    .empty_o (fifo_empty)
  );

  fpra_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .cmd_i       (cmd_out),
    .cmd_empty_i (fifo_empty),
    .cmd_rd_o    (fifo_rd),
    .active_o    (back_active),
    .out_o       (out_o),
    .empty_o     (empty_o),
    .pop_i       (pop_i)
  );

endmodule

`default_nettype wire

### design/fpra_front.sv
// Frame parser: hunts for tags, collects frame bytes, tracks idle ticks and
// the last delivered sequence, and issues one command per finished frame.
// Depends on fpra_pkg.
`default_nettype none

module fpra_front
  import fpra_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire in_t                             in_i,
  input  wire logic                            push_i,
  output logic                                 full_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [15:0]                     cfg_wdata_i,
  input  wire logic                            fifo_full_i,
  input  wire logic                            mem_busy_i,
  output logic                                 cmd_push_o,
  output cmd_t                                 cmd_o,
  output logic                                 mem_we_o,
  output logic [$clog2(BUFFER_BYTES)-1:0]      mem_waddr_o,
  output logic [7:0]                           mem_wdata_o
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int HW = $clog2(BUFFER_BYTES + 1);
  localparam logic [8:0] MaxLen = 9'(BUFFER_BYTES - 2);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [HW-1:0] held_q, held_d;
  logic [7:0]    len_q, len_d;
  logic          tag_ack_q, tag_ack_d;
  logic [7:0]    seq_q, seq_d;
  logic [15:0]   idle_q, idle_d;
  logic [7:0]    last_seq_q, last_seq_d;
  logic [15:0]   timeout_q;

  logic          accept;
  logic [7:0]    b;
  logic [15:0]   idle_inc;
  logic [8:0]    held_next;
  logic [8:0]    total_need;
  logic          payload_write;

  assign b        = in_i.rx_byte;
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

  // Payload bytes go into the back end's store; they must wait while it is
  // still streaming the previous frame from the same entries.
  assign payload_write = (phase_q == PH_BODY) && (held_q >= HW'(3));
  assign full_o        = fifo_full_i || (mem_busy_i && payload_write);
  assign accept        = push_i && !full_o;

  assign held_next  = 9'(held_q) + 9'd1;
  assign total_need = {1'b0, len_q} + 9'd2;

  assign mem_we_o    = accept && (in_i.req_type == ReqByte) && payload_write;
  assign mem_waddr_o = held_q[AW-1:0];
  assign mem_wdata_o = b;

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    len_d      = len_q;
    tag_ack_d  = tag_ack_q;
    seq_d      = seq_q;
    idle_d     = idle_q;
    last_seq_d = last_seq_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: CMD_REJECT, seq: 8'd0, stream: 1'b0, count: 8'd0};

    if (accept) begin
      if (in_i.req_type == ReqTick) begin
        idle_d = idle_inc;
        if (phase_q != PH_HUNT && idle_inc >= timeout_q) begin
          phase_d = PH_HUNT;
        end
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (b == TagData || b == TagAck) begin
              tag_ack_d = (b == TagAck);
              held_d    = HW'(1);
              idle_d    = 16'd0;
              phase_d   = PH_LEN;
            end
          end
          PH_LEN: begin
            if (b == 8'd0 || {1'b0, b} > MaxLen) begin
              phase_d = PH_HUNT;
            end else begin
              len_d   = b;
              held_d  = HW'(2);
              idle_d  = 16'd0;
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            held_d = held_next[HW-1:0];
            idle_d = 16'd0;
            if (held_q == HW'(2)) begin
              seq_d = b;
            end
            if (held_next >= total_need) begin
              // The byte just taken is the frame's last one.
              phase_d    = PH_HUNT;
              cmd_push_o = 1'b1;
              if (held_next < 9'd4 || b != TagEnd || seq_q == SeqNone) begin
                cmd_o.kind = CMD_REJECT;
              end else if (tag_ack_q) begin
                cmd_o.kind = CMD_ACK_RX;
                cmd_o.seq  = seq_q;
              end else begin
                cmd_o.kind   = CMD_DATA;
                cmd_o.seq    = seq_q;
                cmd_o.stream = (seq_q != last_seq_q);
                cmd_o.count  = len_q - 8'd2;
                if (seq_q != last_seq_q) begin
                  last_seq_d = seq_q;
                end
              end
            end
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      held_q     <= '0;
      idle_q     <= 16'd0;
      last_seq_q <= SeqNone;
      timeout_q  <= TimeoutReset;
      len_q      <= 8'd0;
      tag_ack_q  <= 1'b0;
      seq_q      <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      idle_q     <= idle_d;
      last_seq_q <= last_seq_d;
      len_q      <= len_d;
      tag_ack_q  <= tag_ack_d;
      seq_q      <= seq_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

### design/fpra_cmd_fifo.sv
// Two-entry command queue between the frame parser and the result sequencer.
// Depends on fpra_pkg.
`default_nettype none

module fpra_cmd_fifo
  import fpra_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire cmd_t wdata_i,
  output logic      full_o,
  input  wire logic rd_i,
  output cmd_t      rdata_o,
  output logic      empty_o
);

  cmd_t       slots_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slots_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr_q <= !wptr_q;
      end
      if (do_rd) begin
        rptr_q <= !rptr_q;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### design/fpra_back.sv
// Result sequencer: takes frame commands, emits their results through an
// output register and streams payload bytes from the frame store it owns.
// Depends on fpra_pkg.
`default_nettype none

module fpra_back
  import fpra_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       mem_we_i,
  input  wire logic [$clog2(BUFFER_BYTES)-1:0] mem_waddr_i,
  input  wire logic [7:0]                 mem_wdata_i,
  input  wire cmd_t                       cmd_i,
  input  wire logic                       cmd_empty_i,
  output logic                            cmd_rd_o,
  output logic                            active_o,
  output out_t                            out_o,
  output logic                            empty_o,
  input  wire logic                       pop_i
);

  localparam int AW = $clog2(BUFFER_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e     state_q;
  logic       out_valid_q;
  out_t       out_q;
  logic [7:0] idx_q;
  logic [7:0] cnt_q;
  logic [7:0] mem_q [BUFFER_BYTES];
  logic [7:0] rdata_q;
  logic       slot_free;
  logic       out_load;
  logic       rd_en;
  logic [7:0] raddr;

  assign slot_free = !out_valid_q || pop_i;
  assign cmd_rd_o  = (state_q == ST_IDLE) && !cmd_empty_i && slot_free;
  assign out_load  = cmd_rd_o || ((state_q == ST_LOAD) && slot_free);
  assign active_o  = (state_q != ST_IDLE);
  assign rd_en     = (state_q == ST_READ);
  assign raddr     = idx_q + 8'd3;   // payload starts after tag, length, sequence
  assign out_o     = out_q;
  assign empty_o   = !out_valid_q;

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[mem_waddr_i] <= mem_wdata_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      idx_q       <= 8'd0;
      cnt_q       <= 8'd0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_rd_o) begin
            unique case (cmd_i.kind)
              CMD_REJECT: out_q <= '{out_kind: KindReject, out_value: 8'd0, out_last: 1'b1};
              CMD_ACK_RX: out_q <= '{out_kind: KindAckRecv, out_value: cmd_i.seq,
                                     out_last: 1'b1};
              CMD_DATA: begin
                out_q <= '{out_kind: KindAckSend, out_value: cmd_i.seq,
                           out_last: !cmd_i.stream || (cmd_i.count == 8'd0)};
                if (cmd_i.stream && cmd_i.count != 8'd0) begin
                  idx_q   <= 8'd0;
                  cnt_q   <= cmd_i.count;
                  state_q <= ST_READ;
                end
              end
              default: out_q <= '{out_kind: KindReject, out_value: 8'd0, out_last: 1'b1};
            endcase
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (slot_free) begin
            out_q <= '{out_kind: KindPayload, out_value: rdata_q,
                       out_last: (idx_q == cnt_q - 8'd1)};
            if (idx_q == cnt_q - 8'd1) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 8'd1;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/framed_packet_receiver_with_ack_tb.sv
// Testbench for framed_packet_receiver_with_ack: directed frame cases, receive timeout
// cases and random link traffic under several idle patterns, checked against a frame decoder.
// Depends on fpra_pkg and the framed_packet_receiver_with_ack RTL.
`timescale 1ns / 100ps

module framed_packet_receiver_with_ack_tb;
  import fpra_pkg::*;

  localparam int BUFFER_BYTES = 64;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int QUIET_CYCLES = 64;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  in_t         in_i = '0;
  logic        push_i = 1'b0;
  logic        full_o;
  out_t        out_o;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // Decoder state, kept in step with every accepted input transaction.
  parse_phase_e phase = PH_HUNT;
  logic [7:0]   frame_buf [BUFFER_BYTES];
  logic [6:0]   bytes_held = '0;
  logic [15:0]  idle_ticks = '0;
  logic [7:0]   last_data_seq = SeqNone;
  logic [15:0]  rx_timeout = TimeoutReset;

  out_t link_results_due [$];
  out_t due_head;
  int   mismatches = 0;
  int   items_sent = 0;
  int   cycle_cnt = 0;
  int   send_idle_pct = 0;
  int   pop_stall_pct = 0;
  int   frame_tick_pct = 0;

  framed_packet_receiver_with_ack #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .out_o      (out_o),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic out_t result_of(logic [1:0] kind, logic [7:0] value);
    out_t r;
    r.out_kind  = kind;
    r.out_value = value;
    r.out_last  = 1'b0;
    return r;
  endfunction

  // Applies one accepted input transaction to the decoder state and queues the
  // results it causes, the last one flagged.
  task automatic decode_link_item(in_t it);
    out_t        burst [$];
    int unsigned total;
    int unsigned i;
    logic [7:0]  seq;
    if (it.req_type == ReqTick) begin
      if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
      if (phase != PH_HUNT && idle_ticks >= rx_timeout) phase = PH_HUNT;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (it.rx_byte == TagData || it.rx_byte == TagAck) begin
            frame_buf[0] = it.rx_byte;
            bytes_held = 7'd1;
            idle_ticks = '0;
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (it.rx_byte == 8'd0 || int'(it.rx_byte) > BUFFER_BYTES - 2) begin
            phase = PH_HUNT;
          end else begin
            frame_buf[1] = it.rx_byte;
            bytes_held = 7'd2;
            idle_ticks = '0;
            phase = PH_BODY;
          end
        end
        default: begin
          frame_buf[bytes_held[5:0]] = it.rx_byte;
          bytes_held = bytes_held + 7'd1;
          idle_ticks = '0;
          if (int'(bytes_held) >= int'(frame_buf[1]) + 2) begin
            total = int'(bytes_held);
            seq = frame_buf[2];
            if (total < 4 || frame_buf[6'(total - 1)] != TagEnd ||
                seq == SeqNone) begin
              burst.push_back(result_of(KindReject, 8'h00));
            end else if (frame_buf[0] == TagAck) begin
              burst.push_back(result_of(KindAckRecv, seq));
            end else begin
              burst.push_back(result_of(KindAckSend, seq));
              // A repeated sequence is acknowledged again but not delivered twice.
              if (seq != last_data_seq) begin
                for (i = 3; i + 1 < total; i++)
                  burst.push_back(result_of(KindPayload, frame_buf[6'(i)]));
                last_data_seq = seq;
              end
            end
            phase = PH_HUNT;
          end
        end
      endcase
    end
    if (burst.size() > 0) begin
      burst[burst.size() - 1].out_last = 1'b1;
      foreach (burst[k]) link_results_due.push_back(burst[k]);
    end
  endtask

  // Result side: random stalls on pop, every result transaction compared in order.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        if (link_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d value %02h last %0b",
                     out_o.out_kind, out_o.out_value, out_o.out_last);
        end else begin
          due_head = link_results_due.pop_front();
          if (out_o !== due_head) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                       due_head.out_kind, due_head.out_value, due_head.out_last,
                       out_o.out_kind, out_o.out_value, out_o.out_last);
          end
        end
      end
      pop_i <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    items_sent++;
    decode_link_item(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_t it;
    it.req_type = ReqByte;
    it.rx_byte  = b;
    send_item(it);
  endtask

  task automatic send_ticks(int n);
    in_t it;
    repeat (n) begin
      it.req_type = ReqTick;
      it.rx_byte  = 8'($urandom);
      send_item(it);
    end
  endtask

  // Sends a frame with length 1 to 62: tag, length, sequence, payload, end byte.
  task automatic send_frame(logic [7:0] tag, int len, logic [7:0] seq, logic [7:0] end_byte);
    int j;
    send_byte(tag);
    send_byte(8'(len));
    send_byte(seq);
    for (j = 0; j < len - 2; j++) begin
      if ($urandom_range(99) < frame_tick_pct) send_ticks(1);
      send_byte(8'($urandom));
    end
    if (len >= 2) send_byte(end_byte);
  endtask

  task automatic wait_idle();
    push_i <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_rx_timeout(logic [15:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rx_timeout = value;
  endtask

  task automatic test_frame_cases();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    frame_tick_pct = 0;
    // Stray bytes while hunting for a tag.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(TagEnd);
    send_ticks(3);
    send_frame(TagData, BUFFER_BYTES - 2, 8'h00, TagEnd);
    send_frame(TagData, 5, 8'h00, TagEnd);          // repeated sequence
    send_frame(TagData, 2, 8'h01, TagEnd);          // no payload
    send_frame(TagData, 4, 8'h01, TagEnd);          // repeat after the empty frame
    send_frame(TagAck, 2, 8'hFE, TagEnd);
    send_frame(TagAck, 6, 8'h80, TagEnd);
    send_frame(TagData, 3, SeqNone, TagEnd);
    send_frame(TagAck, 2, SeqNone, TagEnd);
    send_frame(TagData, 4, 8'h02, 8'hDD);           // wrong end byte
    send_frame(TagAck, 3, 8'h03, 8'h00);
    send_frame(TagData, 1, 8'h04, TagEnd);          // too short to hold an end byte
    // Length out of range: the length byte is consumed, not retried as a tag.
    send_byte(TagData);
    send_byte(8'h00);
    send_byte(TagData);
    send_byte(8'(BUFFER_BYTES - 1));
    send_byte(TagAck);
    send_byte(TagData);
    send_frame(TagData, 7, 8'h7F, TagEnd);
  endtask

  task automatic test_rx_timeout();
    set_rx_timeout(16'd1);
    send_byte(TagData);
    send_byte(8'd5);
    send_ticks(1);
    send_frame(TagData, 3, 8'h10, TagEnd);
    set_rx_timeout(16'd4);
    // One tick short of the limit keeps the frame, reaching it drops the frame.
    send_byte(TagData);
    send_byte(8'd3);
    send_ticks(3);
    send_byte(8'h11);
    send_ticks(3);
    send_byte(8'h5A);
    send_byte(TagEnd);
    send_byte(TagAck);
    send_byte(8'd2);
    send_ticks(4);
    send_byte(8'h12);
    send_byte(TagEnd);
    set_rx_timeout(16'd0);
    send_byte(TagData);
    send_byte(8'd3);
    send_ticks(1);
    send_byte(TagAck);
    send_ticks(1);
    send_frame(TagData, 2, 8'h13, TagEnd);
    set_rx_timeout(16'hFFFF);
    send_byte(TagData);
    send_byte(8'd4);
    send_ticks(30);
    send_byte(8'h14);
    send_byte(8'hA5);
    send_ticks(30);
    send_byte(8'h3C);
    send_byte(TagEnd);
  endtask

  task automatic send_random_sequence();
    int         pick;
    int         len;
    int         n;
    int         cap;
    logic [7:0] tag;
    logic [7:0] seq;
    logic [7:0] end_byte;
    pick = $urandom_range(99);
    cap = (int'(rx_timeout) > 12) ? 12 : int'(rx_timeout);
    tag = ($urandom_range(99) < 80) ? TagData : TagAck;
    if (pick < 62) begin
      len = ($urandom_range(99) < 10) ? $urandom_range(9, BUFFER_BYTES - 2)
                                       : $urandom_range(2, 8);
      seq = ($urandom_range(99) < 70) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      end_byte = ($urandom_range(99) < 92) ? TagEnd : 8'($urandom);
      send_frame(tag, len, seq, end_byte);
    end else if (pick < 74) begin
      send_ticks($urandom_range(1, cap + 2));
    end else if (pick < 84) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (pick < 92) begin
      send_byte(tag);
      send_byte(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(BUFFER_BYTES - 1, 255)));
    end else if (pick < 96) begin
      send_frame(tag, 1, 8'($urandom), TagEnd);
    end else begin
      // Frame cut short, then left to time out where the limit is reachable.
      len = $urandom_range(3, 10);
      send_byte(tag);
      send_byte(8'(len));
      n = $urandom_range(0, len - 1);
      repeat (n) send_byte(8'($urandom));
      cap = (int'(rx_timeout) > 40) ? 40 : int'(rx_timeout);
      send_ticks(cap + $urandom_range(0, 2));
    end
  endtask

  task automatic run_random_traffic(int n_items, int idle_pct, int stall_pct);
    int start;
    start = items_sent;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    frame_tick_pct = 4;
    while (items_sent - start < n_items) send_random_sequence();
  endtask

  task automatic test_traffic_no_idle();
    set_rx_timeout(16'd12);
    run_random_traffic(52, 0, 0);
  endtask

  task automatic test_traffic_sender_gaps();
    set_rx_timeout(16'd3);
    run_random_traffic(52, 64, 0);
  endtask

  task automatic test_traffic_receiver_stalls();
    set_rx_timeout(16'($urandom_range(2, 20)));
    run_random_traffic(52, 0, 64);
  endtask

  task automatic test_traffic_both_idle();
    set_rx_timeout(16'hFFFF);
    run_random_traffic(52, 12, 12);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_cases();
    test_rx_timeout();
    test_traffic_no_idle();
    test_traffic_sender_gaps();
    test_traffic_receiver_stalls();
    test_traffic_both_idle();
    wait_idle();
    if (mismatches == 0 && link_results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
design/fpra_pkg.sv
design/fpra_front.sv
design/fpra_cmd_fifo.sv
design/fpra_back.sv
design/framed_packet_receiver_with_ack.sv
tb/framed_packet_receiver_with_ack_tb.sv
